// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. Define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed (same-cycle implication)");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed (next-cycle implication)");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/msfp_pkg.sv -----
// ----------------------------------------------------------------------------
// msfp_pkg
// Frame geometry, register indexes and the decoded status record type.
// ----------------------------------------------------------------------------
package msfp_pkg;

    // Total frame length: two headers, length byte, data, checksum.
    localparam int FRAME_LEN   = 25;
    localparam int DATA_LEN    = FRAME_LEN - 4;
    localparam int LEN_VALUE   = FRAME_LEN - 1;
    localparam int STORE_DEPTH = 21;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
    localparam int INDEX_W     = 7;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_HEADER_FIRST  = 1'd0;
    localparam t_cfg_idx CFG_HEADER_SECOND = 1'd1;

    // Decoded status record
    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic        [7:0]  left_motor_state;
        logic        [7:0]  right_motor_state;
        logic        [15:0] left_motor_fault;
        logic        [15:0] right_motor_fault;
        logic        [31:0] obstacle_distances;
        logic        [7:0]  obstacle_flags;
        logic        [7:0]  link_flags;
        logic        [7:0]  io_flags;
        logic               checksum_ok;
    } t_status;

endpackage

// ----- rtl/msfp_deframer.sv -----
// ----------------------------------------------------------------------------
// msfp_deframer
// Header/length hunt, payload capture, running checksum and record decode.
// ----------------------------------------------------------------------------
module msfp_deframer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_header_first,
    input  logic [7:0]       i_header_second,
    output logic             o_frame_end,
    output msfp_pkg::t_status o_status
);
    import msfp_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SECOND,
        PH_LENGTH,
        PH_COLLECT
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [INDEX_W-1:0] r_byte_index, n_byte_index;
    logic [7:0]         r_sum, n_sum;
    logic [7:0]         r_store [STORE_DEPTH];

    logic [7:0] sum_plus;
    logic       store_we;
    logic       sum_match;

    assign sum_plus    = r_sum + i_byte;
    assign o_frame_end = (r_phase == PH_COLLECT) && (r_byte_index == INDEX_W'(DATA_LEN));
    assign store_we    = i_fire && (r_phase == PH_COLLECT) && !o_frame_end
                         && (r_byte_index < INDEX_W'(STORE_DEPTH));
    assign sum_match   = (i_byte == r_sum);

    always_comb begin
        n_phase      = r_phase;
        n_byte_index = r_byte_index;
        n_sum        = r_sum;
        if (i_fire) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == i_header_first) begin
                        n_phase      = PH_SECOND;
                        n_byte_index = '0;
                        n_sum        = i_byte;
                    end
                end
                PH_SECOND: begin
                    if (i_byte == i_header_second) begin
                        n_phase = PH_LENGTH;
                        n_sum   = sum_plus;
                    end else begin
                        n_phase      = PH_HUNT;
                        n_byte_index = '0;
                        n_sum        = '0;
                    end
                end
                PH_LENGTH: begin
                    if (i_byte == 8'(LEN_VALUE)) begin
                        n_phase      = PH_COLLECT;
                        n_byte_index = '0;
                        n_sum        = sum_plus;
                    end else begin
                        n_phase      = PH_HUNT;
                        n_byte_index = '0;
                        n_sum        = '0;
                    end
                end
                PH_COLLECT: begin
                    if (o_frame_end) begin
                        n_phase      = PH_HUNT;
                        n_byte_index = '0;
                        n_sum        = '0;
                    end else begin
                        n_byte_index = r_byte_index + 1'b1;
                        n_sum        = sum_plus;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_byte_index <= '0;
            r_sum        <= '0;
        end else begin
            r_phase      <= n_phase;
            r_byte_index <= n_byte_index;
            r_sum        <= n_sum;
        end
    end

    // Payload store, no reset: every entry is rewritten in each frame
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_byte_index[STORE_IDX_W-1:0]] <= i_byte;
        end
    end

    // Record decode; a bad checksum gives an all-zero record
    always_comb begin
        o_status = '0;
        if (sum_match) begin
            o_status.left_count         = {r_store[0], r_store[1], r_store[2], r_store[3]};
            o_status.right_count        = {r_store[4], r_store[5], r_store[6], r_store[7]};
            o_status.left_motor_state   = r_store[8];
            o_status.right_motor_state  = r_store[9];
            o_status.left_motor_fault   = {r_store[10], r_store[11]};
            o_status.right_motor_fault  = {r_store[12], r_store[13]};
            o_status.obstacle_distances = {r_store[17], r_store[16], r_store[15], r_store[14]};
            o_status.obstacle_flags     = r_store[18];
            o_status.link_flags         = r_store[19];
            o_status.io_flags           = r_store[20];
            o_status.checksum_ok        = 1'b1;
        end
    end

endmodule

// ----- rtl/msfp_result_reg.sv -----
// ----------------------------------------------------------------------------
// msfp_result_reg
// Output register holding one decoded record until the transfer completes.
// ----------------------------------------------------------------------------
module msfp_result_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  msfp_pkg::t_status i_status,
    input  logic              i_stall,
    output logic              o_valid,
    output msfp_pkg::t_status o_status
);
    import msfp_pkg::*;

    logic    r_valid, n_valid;
    t_status r_status;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= i_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;

endmodule

// ----- rtl/motor_status_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// motor_status_frame_parser_core
// Deframes motor-controller status frames from a received byte stream.
// ----------------------------------------------------------------------------
// One received byte is taken per transfer on the input channel; unless
// stalled, a new byte can be taken every clock cycle: each byte passes
// an input register, a deframer state update, and for the checksum byte a
// load of the output register. The parser hunts for the two header bytes
// (registers 0 and 1, reset 0x55 and 0xAA), then a length byte equal to
// FRAME_LEN-1; any mismatch sends it back to the hunt, and the byte that
// failed is not retried as a first header. It then collects FRAME_LEN-4
// data bytes and a checksum byte, the mod-256 sum of the headers, length
// and data. On the checksum byte one record goes out, with checksum_ok set
// on a match; on a mismatch every field is zero. Input stall rises only
// when a finished record still sits, stalled, in the output register and
// the next byte would complete another frame. Header registers must be
// written by the user only while no byte is in flight; the block itself
// does not enforce this. A change part-way through a frame leaves the
// headers already matched in the running sum.
// ----------------------------------------------------------------------------
module motor_status_frame_parser_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [msfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                i_cfg_data,
    // byte input
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_rx_byte,
    // record output
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [31:0]        o_left_count,
    output logic signed [31:0]        o_right_count,
    output logic [7:0]                o_left_motor_state,
    output logic [7:0]                o_right_motor_state,
    output logic [15:0]               o_left_motor_fault,
    output logic [15:0]               o_right_motor_fault,
    output logic [31:0]               o_obstacle_distances,
    output logic [7:0]                o_obstacle_flags,
    output logic [7:0]                o_link_flags,
    output logic [7:0]                o_io_flags,
    output logic                      o_checksum_ok
);
    import msfp_pkg::*;

    `include "assert_macros.svh"

    // Header match values
    logic [7:0] r_header_first;
    logic [7:0] r_header_second;

    // Input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;

    logic    in_accept;
    logic    out_ready;
    logic    frame_end;
    logic    fire;
    t_status dec_status;
    t_status out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= 8'h55;
            r_header_second <= 8'hAA;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEADER_FIRST:  r_header_first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_header_second <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The held byte moves on unless it completes a frame while the
    // output register is full and stalled.
    assign out_ready  = !o_out_valid || !i_out_stall;
    assign fire       = r_in_valid && (!frame_end || out_ready);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    msfp_deframer u_deframer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_byte          (r_in_byte),
        .i_header_first  (r_header_first),
        .i_header_second (r_header_second),
        .o_frame_end     (frame_end),
        .o_status        (dec_status)
    );

    msfp_result_reg u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && frame_end),
        .i_status (dec_status),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_status (out_status)
    );

    assign o_left_count         = out_status.left_count;
    assign o_right_count        = out_status.right_count;
    assign o_left_motor_state   = out_status.left_motor_state;
    assign o_right_motor_state  = out_status.right_motor_state;
    assign o_left_motor_fault   = out_status.left_motor_fault;
    assign o_right_motor_fault  = out_status.right_motor_fault;
    assign o_obstacle_distances = out_status.obstacle_distances;
    assign o_obstacle_flags     = out_status.obstacle_flags;
    assign o_link_flags         = out_status.link_flags;
    assign o_io_flags           = out_status.io_flags;
    assign o_checksum_ok        = out_status.checksum_ok;

    // A failed checksum carries an all-zero record
    `ASSERT_IMPL(a_bad_sum_zero, i_clk, i_rst_n, o_out_valid && !o_checksum_ok, out_status == '0)
    // A completed frame always lands in the output register
    `ASSERT_NEXT(a_frame_to_out, i_clk, i_rst_n, fire && frame_end, o_out_valid)
    // A held record is never overwritten by the next frame
    `ASSERT_IMPL(a_no_overrun, i_clk, i_rst_n, r_in_valid && frame_end && !out_ready, o_in_stall)

endmodule
